### hw/rtl/hrt_pkg.sv
package hrt_pkg;

  // Byte codes
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;

  // Result roles
  localparam logic [2:0] ROLE_METHOD  = 3'd0;
  localparam logic [2:0] ROLE_PATH    = 3'd1;
  localparam logic [2:0] ROLE_VERSION = 3'd2;
  localparam logic [2:0] ROLE_KEY     = 3'd3;
  localparam logic [2:0] ROLE_VALUE   = 3'd4;
  localparam logic [2:0] ROLE_DELIM   = 3'd5;
  localparam logic [2:0] ROLE_STATUS  = 3'd6;

  // Final status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_M_SPACE  = 3'd1;
  localparam logic [2:0] ST_BAD_METHOD  = 3'd2;
  localparam logic [2:0] ST_NO_P_SPACE  = 3'd3;
  localparam logic [2:0] ST_NO_V_CRLF   = 3'd4;

  // Results one input beat can cause
  localparam int MAX_RES = 3;

  // Method table
  localparam int METHOD_COUNT = 9;
  localparam int METHOD_CHARS = 8;

  localparam logic [7:0] VERB_TEXT [METHOD_COUNT][METHOD_CHARS] = '{
    '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
    '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
    '{"P", "A", "T", "C", "H", 8'h00, 8'h00, 8'h00},
    '{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00},
    '{"C", "O", "N", "N", "E", "C", "T", 8'h00}
  };

  localparam logic [2:0] VERB_LEN [METHOD_COUNT] = '{
    3'd3, 3'd4, 3'd3, 3'd6, 3'd4, 3'd7, 3'd5, 3'd5, 3'd7
  };

  // Parse phase
  typedef enum logic [6:0] {
    PH_METHOD  = 7'b0000001,
    PH_PATH    = 7'b0000010,
    PH_VERSION = 7'b0000100,
    PH_KEY     = 7'b0001000,
    PH_VALUE   = 7'b0010000,
    PH_BODY    = 7'b0100000,
    PH_FAILED  = 7'b1000000
  } phase_t;

  // One result item, run_last is added at the output
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] role;
    logic       kept;
    logic [2:0] status;
  } res_t;

  // All results of one input beat
  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [1:0]         count;
  } bundle_t;

endpackage

### hw/rtl/hrt_step.sv
module hrt_step
  import hrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  output bundle_t    bundle
);

  typedef struct packed {
    phase_t                    phase;
    logic [METHOD_COUNT-1:0]   method_match;
    logic [2:0]                method_pos;
    logic                      cr_held;
    logic                      colon_seen;
    logic                      line_empty;
    logic [2:0]                fail_code;
  } pstate_t;

  typedef struct packed {
    pstate_t st;
    logic    emit;
    res_t    res;
  } content_t;

  typedef struct packed {
    pstate_t st;
    res_t    cr;
    res_t    lf;
  } line_t;

  localparam pstate_t RESET_ST = '{
    phase:        PH_METHOD,
    method_match: '1,
    method_pos:   3'd0,
    cr_held:      1'b0,
    colon_seen:   1'b0,
    line_empty:   1'b1,
    fail_code:    3'd0
  };

  pstate_t state;
  pstate_t state_next;

  function automatic res_t mk_res(logic [7:0] b, logic [2:0] r, logic k, logic [2:0] s);
    res_t x;
    x.data   = b;
    x.role   = r;
    x.kept   = k;
    x.status = s;
    return x;
  endfunction

  // Tag one content byte and advance the phase
  function automatic content_t content(pstate_t s, logic [7:0] b);
    content_t c;
    logic     ok;
    c.st   = s;
    c.emit = 1'b0;
    c.res  = '0;
    ok     = 1'b0;
    unique case (s.phase)
      PH_METHOD: begin
        c.emit = 1'b1;
        if (b == CH_SP) begin
          for (int k = 0; k < METHOD_COUNT; k++) begin
            if (s.method_match[k] && (VERB_LEN[k] == s.method_pos)) ok = 1'b1;
          end
          c.res = mk_res(b, ROLE_DELIM, 1'b0, ST_OK);
          if (ok) begin
            c.st.phase = PH_PATH;
          end else begin
            c.st.phase     = PH_FAILED;
            c.st.fail_code = ST_BAD_METHOD;
          end
        end else begin
          for (int k = 0; k < METHOD_COUNT; k++) begin
            if (!((s.method_pos < VERB_LEN[k]) && (VERB_TEXT[k][s.method_pos] == b)))
              c.st.method_match[k] = 1'b0;
          end
          if (s.method_pos != 3'd7) begin
            c.st.method_pos = 3'(s.method_pos + 3'd1);
          end else begin
            c.st.method_match = '0;
          end
          c.res = mk_res(b, ROLE_METHOD, 1'b0, ST_OK);
        end
      end
      PH_PATH: begin
        c.emit = 1'b1;
        if (b == CH_SP) begin
          c.res      = mk_res(b, ROLE_DELIM, 1'b0, ST_OK);
          c.st.phase = PH_VERSION;
        end else begin
          c.res = mk_res(b, ROLE_PATH, 1'b0, ST_OK);
        end
      end
      PH_VERSION: begin
        c.emit = 1'b1;
        c.res  = mk_res(b, ROLE_VERSION, 1'b0, ST_OK);
      end
      PH_KEY: begin
        c.emit          = 1'b1;
        c.st.line_empty = 1'b0;
        if (b == CH_COLON) begin
          c.res           = mk_res(b, ROLE_DELIM, 1'b0, ST_OK);
          c.st.colon_seen = 1'b1;
          c.st.phase      = PH_VALUE;
        end else begin
          c.res = mk_res(b, ROLE_KEY, 1'b0, ST_OK);
        end
      end
      PH_VALUE: begin
        c.emit          = 1'b1;
        c.st.line_empty = 1'b0;
        c.res           = mk_res(b, ROLE_VALUE, 1'b0, ST_OK);
      end
      default: begin
        c.emit = 1'b0;
      end
    endcase
    return c;
  endfunction

  // Close a line on CRLF
  function automatic line_t close_line(pstate_t s);
    line_t l;
    l.st = s;
    l.cr = mk_res(CH_CR, ROLE_DELIM, 1'b0, ST_OK);
    if (s.phase == PH_VERSION) begin
      l.lf       = mk_res(CH_LF, ROLE_DELIM, 1'b0, ST_OK);
      l.st.phase = PH_KEY;
    end else begin
      l.lf       = mk_res(CH_LF, ROLE_DELIM, s.colon_seen, ST_OK);
      l.st.phase = s.line_empty ? PH_BODY : PH_KEY;
    end
    l.st.colon_seen = 1'b0;
    l.st.line_empty = 1'b1;
    return l;
  endfunction

  // Work out the results and next state of one beat
  always_comb begin
    pstate_t    s;
    content_t   c;
    line_t      l;
    logic [1:0] n;
    logic       done;
    logic [2:0] st;
    s      = state;
    n      = 2'd0;
    done   = 1'b0;
    st     = ST_OK;
    bundle = '0;
    c      = '0;
    l      = '0;

    // resolve a held CR
    if (s.cr_held) begin
      s.cr_held = 1'b0;
      if (in_byte == CH_LF) begin
        l                = close_line(s);
        s                = l.st;
        bundle.res[0]    = l.cr;
        bundle.res[1]    = l.lf;
        n                = 2'd2;
        done             = 1'b1;
      end else begin
        c = content(s, CH_CR);
        s = c.st;
        if (c.emit) begin
          bundle.res[n] = c.res;
          n             = 2'(n + 2'd1);
        end
      end
    end

    // hold a CR or tag the byte
    if (!done) begin
      if ((in_byte == CH_CR) &&
          (s.phase == PH_VERSION || s.phase == PH_KEY || s.phase == PH_VALUE)) begin
        s.cr_held = 1'b1;
      end else begin
        c = content(s, in_byte);
        s = c.st;
        if (c.emit) begin
          bundle.res[n] = c.res;
          n             = 2'(n + 2'd1);
        end
      end
    end

    // flush and report status on the last beat
    if (is_last) begin
      if (s.cr_held) begin
        s.cr_held = 1'b0;
        c         = content(s, CH_CR);
        s         = c.st;
        if (c.emit && n != 2'd3) begin
          bundle.res[n] = c.res;
          n             = 2'(n + 2'd1);
        end
      end
      if (s.fail_code != 3'd0)         st = s.fail_code;
      else if (s.phase == PH_METHOD)   st = ST_NO_M_SPACE;
      else if (s.phase == PH_PATH)     st = ST_NO_P_SPACE;
      else if (s.phase == PH_VERSION)  st = ST_NO_V_CRLF;
      else                             st = ST_OK;
      if (n != 2'd3) begin
        bundle.res[n] = mk_res(8'h00, ROLE_STATUS, 1'b0, st);
        n             = 2'(n + 2'd1);
      end
      s = RESET_ST;
    end

    bundle.count = n;
    state_next   = s;
  end

  // Advance the parse state per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RESET_ST;
    end else if (advance) begin
      state <= state_next;
    end
  end

  a_cr_phase: assert property (@(posedge clk) disable iff (rst)
    state.cr_held |->
      (state.phase == PH_VERSION || state.phase == PH_KEY || state.phase == PH_VALUE))
    else $error("CR held outside version or header part");

  a_fail_phase: assert property (@(posedge clk) disable iff (rst)
    (state.fail_code != 3'd0) |-> (state.phase == PH_FAILED))
    else $error("fail code set outside failed phase");

  a_pos_match: assert property (@(posedge clk) disable iff (rst)
    (state.method_pos == 3'd0) |-> (state.method_match == '1))
    else $error("method match narrowed before any method byte");

  a_last_reset: assert property (@(posedge clk) disable iff (rst)
    (advance && is_last) |=> (state == RESET_ST))
    else $error("state not returned to reset after last beat");

endmodule

### hw/rtl/hrt_out.sv
module hrt_out
  import hrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  bundle_t    bundle,
  output logic       free,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [2:0] role,
  output logic       line_kept,
  output logic [2:0] status,
  output logic       run_last
);

  bundle_t    held;
  logic       valid;
  logic [1:0] idx;
  logic       at_end;
  res_t       cur;

  assign at_end = (idx == 2'(held.count - 2'd1));
  assign free   = !valid || (out_ready && at_end);
  assign cur    = held.res[idx];

  assign out_valid = valid;
  assign out_byte  = cur.data;
  assign role      = cur.role;
  assign line_kept = cur.kept;
  assign status    = cur.status;
  assign run_last  = at_end;

  // Hold the valid flag and beat index
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else if (load) begin
      valid <= (bundle.count != 2'd0);
      idx   <= 2'd0;
    end else if (valid && out_ready) begin
      if (at_end) begin
        valid <= 1'b0;
        idx   <= 2'd0;
      end else begin
        idx <= 2'(idx + 2'd1);
      end
    end
  end

  // Capture the results of a beat
  always_ff @(posedge clk) begin
    if (load) begin
      held <= bundle;
    end
  end

  a_count: assert property (@(posedge clk) disable iff (rst)
    valid |-> (held.count != 2'd0 && idx < held.count))
    else $error("output index beyond held results");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("results loaded over undelivered beats");

  a_step: assert property (@(posedge clk) disable iff (rst)
    (valid && out_ready && !at_end && !load) |=> (valid && idx == 2'($past(idx) + 2'd1)))
    else $error("output index did not step");

endmodule

### hw/rtl/http_request_head_tokenizer_core.sv
// Channel  Handshake            Payload
// input    in_valid / in_ready  in_byte[7:0], is_last
// output   out_valid/out_ready  out_byte[7:0], role[2:0], line_kept, status[2:0], run_last
//
// One input byte per cycle enters an input register while in_ready is high; the tokenizer
// logic turns it into zero to three results that load an output register once it is free.
// The output drains one result per cycle while out_ready is high, and the input register
// holds a byte until the output has taken the last result before it; the output drain sets the rate.
// Reset (rst, synchronous) empties both registers and returns the parser to the method
// phase. A stall on out_ready holds the output and, once the input register is full,
// drops in_ready.
module http_request_head_tokenizer_core
  import hrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [2:0] role,
  output logic       line_kept,
  output logic [2:0] status,
  output logic       run_last
);

  logic       q_valid;
  logic [7:0] q_byte;
  logic       q_last;
  logic       free;
  logic       advance;
  bundle_t    bundle;

  assign advance  = q_valid && free;
  assign in_ready = !q_valid || advance;

  // Hold the input beat until the output side can take its results
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_byte <= in_byte;
      q_last <= is_last;
    end
  end

  hrt_step u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .in_byte (q_byte),
    .is_last (q_last),
    .bundle  (bundle)
  );

  hrt_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .bundle    (bundle),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .role      (role),
    .line_kept (line_kept),
    .status    (status),
    .run_last  (run_last)
  );

endmodule

### test/tokenizer_checker.sv
`timescale 1ns / 100ps

module tokenizer_checker
  import hrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic [2:0] role,
  input  logic       line_kept,
  input  logic [2:0] status,
  input  logic       run_last,
  output int         fail_count,
  output int         tokens_due
);

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] role;
    logic       kept;
    logic [2:0] status;
    logic       last;
  } token_t;

  token_t expected_tokens [$];
  token_t beat_tokens [MAX_RES];
  int     beat_count;

  // Parser state of the request being tokenized
  phase_t     ph;
  logic [8:0] verb_alive;
  logic [2:0] verb_pos;
  logic       cr_hold;
  logic       colon_hit;
  logic       blank_line;
  logic [2:0] fail_code;

  function automatic string verb_name(int k);
    case (k)
      0: return "GET";
      1: return "POST";
      2: return "PUT";
      3: return "DELETE";
      4: return "HEAD";
      5: return "OPTIONS";
      6: return "PATCH";
      7: return "TRACE";
      default: return "CONNECT";
    endcase
  endfunction

  function void clear_parser();
    ph         = PH_METHOD;
    verb_alive = '1;
    verb_pos   = '0;
    cr_hold    = 1'b0;
    colon_hit  = 1'b0;
    blank_line = 1'b1;
    fail_code  = ST_OK;
  endfunction

  function void put_token(logic [7:0] b, logic [2:0] r, logic k, logic [2:0] s);
    if (beat_count < MAX_RES) begin
      beat_tokens[beat_count] = '{data: b, role: r, kept: k, status: s, last: 1'b0};
      beat_count++;
    end
  endfunction

  // Tag one content byte according to the current phase
  function void take_char(logic [7:0] b);
    logic  ok;
    string name;
    ok = 1'b0;
    case (ph)
      PH_METHOD: begin
        if (b == CH_SP) begin
          for (int k = 0; k < 9; k++) begin
            name = verb_name(k);
            if (verb_alive[k] && name.len() == int'(verb_pos)) ok = 1'b1;
          end
          put_token(b, ROLE_DELIM, 1'b0, ST_OK);
          if (ok) begin
            ph = PH_PATH;
          end else begin
            ph        = PH_FAILED;
            fail_code = ST_BAD_METHOD;
          end
        end else begin
          for (int k = 0; k < 9; k++) begin
            name = verb_name(k);
            if (!(int'(verb_pos) < name.len() && 8'(name[verb_pos]) == b))
              verb_alive[k] = 1'b0;
          end
          // saturate the position; an eighth letter kills every method
          if (verb_pos < 3'd7) verb_pos = verb_pos + 3'd1;
          else verb_alive = '0;
          put_token(b, ROLE_METHOD, 1'b0, ST_OK);
        end
      end
      PH_PATH: begin
        if (b == CH_SP) begin
          put_token(b, ROLE_DELIM, 1'b0, ST_OK);
          ph = PH_VERSION;
        end else begin
          put_token(b, ROLE_PATH, 1'b0, ST_OK);
        end
      end
      PH_VERSION: put_token(b, ROLE_VERSION, 1'b0, ST_OK);
      PH_KEY: begin
        blank_line = 1'b0;
        if (b == CH_COLON) begin
          put_token(b, ROLE_DELIM, 1'b0, ST_OK);
          colon_hit = 1'b1;
          ph        = PH_VALUE;
        end else begin
          put_token(b, ROLE_KEY, 1'b0, ST_OK);
        end
      end
      PH_VALUE: begin
        blank_line = 1'b0;
        put_token(b, ROLE_VALUE, 1'b0, ST_OK);
      end
      default: ;
    endcase
  endfunction

  // Close a line on CRLF
  function void end_line();
    put_token(CH_CR, ROLE_DELIM, 1'b0, ST_OK);
    if (ph == PH_VERSION) begin
      put_token(CH_LF, ROLE_DELIM, 1'b0, ST_OK);
      ph = PH_KEY;
    end else begin
      put_token(CH_LF, ROLE_DELIM, colon_hit, ST_OK);
      ph = blank_line ? PH_BODY : PH_KEY;
    end
    colon_hit  = 1'b0;
    blank_line = 1'b1;
  endfunction

  // Work out every result one input beat causes and queue them
  function void tokenize_byte(logic [7:0] b, logic last);
    logic       done;
    logic [2:0] st;
    beat_count = 0;
    done       = 1'b0;
    if (cr_hold) begin
      cr_hold = 1'b0;
      if (b == CH_LF) begin
        end_line();
        done = 1'b1;
      end else begin
        take_char(CH_CR);
      end
    end
    if (!done) begin
      if (b == CH_CR && ph inside {PH_VERSION, PH_KEY, PH_VALUE}) cr_hold = 1'b1;
      else take_char(b);
    end
    if (last) begin
      if (cr_hold) begin
        cr_hold = 1'b0;
        take_char(CH_CR);
      end
      if (fail_code != ST_OK) st = fail_code;
      else if (ph == PH_METHOD) st = ST_NO_M_SPACE;
      else if (ph == PH_PATH) st = ST_NO_P_SPACE;
      else if (ph == PH_VERSION) st = ST_NO_V_CRLF;
      else st = ST_OK;
      put_token(8'h00, ROLE_STATUS, 1'b0, st);
      clear_parser();
    end
    if (beat_count > 0) beat_tokens[beat_count-1].last = 1'b1;
    for (int i = 0; i < beat_count; i++) expected_tokens.push_back(beat_tokens[i]);
  endfunction

  function void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Compare results first, then predict from the input beat of the same edge
  always @(posedge clk) begin : watch
    token_t want;
    if (rst) begin
      clear_parser();
      expected_tokens.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected result beat: out_byte %0h role %0d", out_byte, role);
          fail_count++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("out_byte", want.data, out_byte);
          check_field("role", want.role, role);
          check_field("line_kept", want.kept, line_kept);
          check_field("status", want.status, status);
          check_field("run_last", want.last, run_last);
        end
      end
      if (in_valid && in_ready) tokenize_byte(in_byte, is_last);
    end
    tokens_due = expected_tokens.size();
  end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench
  import hrt_pkg::*;
();

  localparam int ITEM_TARGET  = 310;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       is_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic [2:0] role;
  logic       line_kept;
  logic [2:0] status;
  logic       run_last;

  int fail_count;
  int tokens_due;
  int idle_pct     = 0;
  int quiet_cycles = 0;

  logic [7:0] draft [$];
  logic [7:0] feed_bytes [$];
  logic       feed_last [$];

  http_request_head_tokenizer_core dut (.*);

  tokenizer_checker u_checker (.*);

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Abort when neither channel moves a beat for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function void add_str(string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(8'(s[i]));
  endfunction

  function void add_crlf();
    draft.push_back(CH_CR);
    draft.push_back(CH_LF);
  endfunction

  function automatic logic [7:0] text_char(int wild_pct);
    if ($urandom_range(0, 99) < wild_pct) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h21, 8'h7e));
  endfunction

  // Move the draft request into the feed, maybe cut short at a random byte
  function void commit_draft(logic may_cut);
    int cut;
    cut = draft.size();
    if (may_cut && $urandom_range(0, 4) == 0) cut = $urandom_range(1, draft.size());
    for (int i = 0; i < cut; i++) begin
      feed_bytes.push_back(draft[i]);
      feed_last.push_back(i == cut - 1);
    end
    draft.delete();
  endfunction

  function void random_request();
    int k;
    int n;
    int sel;
    if ($urandom_range(0, 9) == 0) begin
      // raw noise
      repeat ($urandom_range(1, 12)) draft.push_back(8'($urandom_range(0, 255)));
    end else begin
      // method: mostly valid, sometimes short, long or made up
      k   = $urandom_range(0, METHOD_COUNT - 1);
      n   = VERB_LEN[k];
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        repeat ($urandom_range(1, 9)) draft.push_back(8'($urandom_range("A", "Z")));
      end else begin
        if (sel == 1) n = n - 1;
        for (int i = 0; i < n; i++) draft.push_back(VERB_TEXT[k][i]);
        if (sel == 2) draft.push_back(8'($urandom_range("A", "Z")));
      end
      add_str(" /");
      repeat ($urandom_range(0, 6)) draft.push_back(text_char(5));
      add_str(" HTTP/1.");
      if ($urandom_range(0, 9) == 0) draft.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
      add_str("1");
      add_crlf();
      // header lines, some without a colon, some with a lone CR
      repeat ($urandom_range(0, 3)) begin
        repeat ($urandom_range(1, 5)) draft.push_back(text_char(3));
        if ($urandom_range(0, 4) != 0) begin
          draft.push_back(CH_COLON);
          repeat ($urandom_range(0, 6)) begin
            sel = $urandom_range(0, 5);
            if (sel == 0) draft.push_back(CH_COLON);
            else if (sel == 1) draft.push_back(CH_SP);
            else draft.push_back(text_char(3));
          end
        end
        if ($urandom_range(0, 7) == 0) begin
          draft.push_back(CH_CR);
          draft.push_back(text_char(10));
        end
        add_crlf();
      end
      if ($urandom_range(0, 9) != 0) add_crlf();
      repeat ($urandom_range(0, 4)) draft.push_back(8'($urandom_range(0, 255)));
    end
    commit_draft(1'b1);
  endfunction

  // Result sink: random stall bursts while idle_pct is nonzero
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    in_byte  = 8'h00;
    is_last  = 1'b0;

    // Directed requests: byte extremes, bad method, held CR at the end,
    // a full head with kept and dropped header lines plus a body byte
    draft.push_back(8'hff);
    commit_draft(1'b0);
    draft.push_back(8'h00);
    add_str(" ");
    commit_draft(1'b0);
    add_str("GET / ");
    draft.push_back(CH_CR);
    commit_draft(1'b0);
    add_str("GET / ");
    add_crlf();
    add_str("k:v");
    add_crlf();
    add_str("x");
    add_crlf();
    add_crlf();
    add_str("z");
    commit_draft(1'b0);

    while (feed_bytes.size() < ITEM_TARGET) random_request();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int idx = 0; idx < feed_bytes.size(); idx++) begin
      // change the idling rate now and then; none in the last stretch
      if (idx % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: idle_pct = 0;
          1: idle_pct = 10;
          2: idle_pct = 25;
          default: idle_pct = 50;
        endcase
      end
      if (idx >= feed_bytes.size() * 85 / 100) idle_pct = 0;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      in_valid = 1'b1;
      in_byte  = feed_bytes[idx];
      is_last  = feed_last[idx];
      do @(posedge clk); while (!in_ready);
      @(negedge clk);
    end
    in_valid = 1'b0;

    // Drain the outstanding results, then give the block a few more cycles
    while (tokens_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
